FILE: rtl/dpft_pkg.sv
// shared types, codes and constants of the direct path freshness tracker
package dpft_pkg;

    localparam int SOURCE_COUNT = 6;
    localparam int SRC_W        = 3;
    localparam int TIME_W       = 32;
    localparam int GEN_W        = 32;
    localparam int FAIL_W       = 8;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;

    localparam logic [SRC_W:0]      SOURCE_LIMIT      = (SRC_W + 1)'(SOURCE_COUNT);
    localparam logic [GEN_W-1:0]    GEN_MAX           = '1;
    localparam logic [FAIL_W-1:0]   FAIL_MAX          = '1;
    localparam logic [TIME_W-1:0]   MAX_AGE_RESET     = 32'd600000;
    localparam logic [FAIL_W-1:0]   FAIL_THRESH_RESET = 8'd3;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_LEARN  = 2'd1,
        OP_EXPIRE = 2'd2,
        OP_NOTE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        LIFE_NONE    = 2'd0,
        LIFE_VALID   = 2'd1,
        LIFE_EXPIRED = 2'd2,
        LIFE_FAILED  = 2'd3
    } life_t;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_APPLIED = 2'd1,
        ST_STALE   = 2'd2,
        ST_FLOOD   = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_AGE     = 1'b0,
        CFG_FAIL_THRESH = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        op_t                opcode;
        logic [SRC_W-1:0]   path_source;
        logic [TIME_W-1:0]  now_ms;
        logic [GEN_W-1:0]   claimed_gen;
        logic               success;
    } item_t;

    typedef struct packed {
        life_t              life;
        logic [SRC_W-1:0]   source;
        logic [GEN_W-1:0]   generation;
        logic [TIME_W-1:0]  learned_time;
        logic [TIME_W-1:0]  success_time;
        logic [TIME_W-1:0]  failure_time;
        logic [TIME_W-1:0]  expiry_time;
        logic [FAIL_W-1:0]  fail_run;
        logic               had_success;
    } path_state_t;

    typedef struct packed {
        status_t            status;
        life_t              lifecycle;
        logic [GEN_W-1:0]   generation_out;
        logic [SRC_W-1:0]   source_out;
        logic [FAIL_W-1:0]  failure_count;
        logic [TIME_W-1:0]  validated_at_ms;
        logic [TIME_W-1:0]  stale_after_ms;
        logic [TIME_W-1:0]  failed_at_ms;
    } result_t;

    typedef struct packed {
        logic [TIME_W-1:0]  max_age_ms;
        logic [FAIL_W-1:0]  failure_threshold;
    } cfg_t;

endpackage

FILE: rtl/dpft_chan_if.sv
// valid/ready channel interfaces for requests and responses
interface dpft_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           opcode;
    logic [dpft_pkg::SRC_W-1:0]           path_source;
    logic [dpft_pkg::TIME_W-1:0]          now_ms;
    logic [dpft_pkg::GEN_W-1:0]           claimed_gen;
    logic                                 success;

    modport source (
        output valid, opcode, path_source, now_ms, claimed_gen, success,
        input  ready
    );
    modport sink (
        input  valid, opcode, path_source, now_ms, claimed_gen, success,
        output ready
    );
endinterface

interface dpft_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           status;
    logic [1:0]                           lifecycle;
    logic [dpft_pkg::GEN_W-1:0]           generation_out;
    logic [dpft_pkg::SRC_W-1:0]           source_out;
    logic [dpft_pkg::FAIL_W-1:0]          failure_count;
    logic [dpft_pkg::TIME_W-1:0]          validated_at_ms;
    logic [dpft_pkg::TIME_W-1:0]          stale_after_ms;
    logic [dpft_pkg::TIME_W-1:0]          failed_at_ms;

    modport source (
        output valid, status, lifecycle, generation_out, source_out, failure_count,
               validated_at_ms, stale_after_ms, failed_at_ms,
        input  ready
    );
    modport sink (
        input  valid, status, lifecycle, generation_out, source_out, failure_count,
               validated_at_ms, stale_after_ms, failed_at_ms,
        output ready
    );
endinterface

FILE: rtl/dpft_step.sv
// next path state and response for one operation
module dpft_step (
    input  dpft_pkg::item_t       item,
    input  dpft_pkg::path_state_t cur,
    input  dpft_pkg::cfg_t        cfg,
    output dpft_pkg::path_state_t nxt,
    output dpft_pkg::result_t     result
);

    logic [dpft_pkg::TIME_W-1:0] refresh;
    logic [dpft_pkg::TIME_W-1:0] age;
    logic [dpft_pkg::TIME_W-1:0] new_expiry;
    logic [dpft_pkg::GEN_W-1:0]  gen_bumped;
    logic [dpft_pkg::FAIL_W-1:0] fail_run_inc;
    logic                        learn_ok;
    logic                        stale;
    dpft_pkg::status_t           status;

    assign refresh    = cur.had_success ? cur.success_time : cur.learned_time;
    assign age        = item.now_ms - refresh;
    assign new_expiry = item.now_ms + cfg.max_age_ms;
    assign gen_bumped = (cur.generation == dpft_pkg::GEN_MAX) ? cur.generation
                                                              : cur.generation + 1'b1;
    assign fail_run_inc = (cur.fail_run == dpft_pkg::FAIL_MAX) ? cur.fail_run
                                                               : cur.fail_run + 1'b1;
    assign learn_ok = (item.path_source != '0)
                   && ({1'b0, item.path_source} < dpft_pkg::SOURCE_LIMIT)
                   && (cur.generation != dpft_pkg::GEN_MAX);
    assign stale = (item.claimed_gen == '0)
                || (item.claimed_gen != cur.generation)
                || (cur.life != dpft_pkg::LIFE_VALID);

    always_comb
    begin
        nxt    = cur;
        status = dpft_pkg::ST_NONE;
        case (item.opcode)
            dpft_pkg::OP_CLEAR:
            begin
                nxt    = '0;
                status = dpft_pkg::ST_APPLIED;
            end
            dpft_pkg::OP_LEARN:
            begin
                if (learn_ok)
                begin
                    nxt              = '0;
                    nxt.life         = dpft_pkg::LIFE_VALID;
                    nxt.source       = item.path_source;
                    nxt.generation   = cur.generation + 1'b1;
                    nxt.learned_time = item.now_ms;
                    nxt.expiry_time  = new_expiry;
                    status           = dpft_pkg::ST_APPLIED;
                end
            end
            dpft_pkg::OP_EXPIRE:
            begin
                if (cur.life == dpft_pkg::LIFE_VALID && age > cfg.max_age_ms)
                begin
                    nxt.life       = dpft_pkg::LIFE_EXPIRED;
                    nxt.generation = gen_bumped;
                    status         = dpft_pkg::ST_APPLIED;
                end
            end
            dpft_pkg::OP_NOTE:
            begin
                if (stale)
                begin
                    status = dpft_pkg::ST_STALE;
                end
                else if (item.success)
                begin
                    nxt.success_time = item.now_ms;
                    nxt.had_success  = 1'b1;
                    nxt.expiry_time  = new_expiry;
                    nxt.fail_run     = '0;
                    status           = dpft_pkg::ST_APPLIED;
                end
                else
                begin
                    nxt.failure_time = item.now_ms;
                    nxt.fail_run     = fail_run_inc;
                    if (fail_run_inc < cfg.failure_threshold)
                    begin
                        status = dpft_pkg::ST_APPLIED;
                    end
                    else
                    begin
                        nxt.life       = dpft_pkg::LIFE_FAILED;
                        nxt.generation = gen_bumped;
                        status         = dpft_pkg::ST_FLOOD;
                    end
                end
            end
            default:
            begin
                nxt    = cur;
                status = dpft_pkg::ST_NONE;
            end
        endcase
    end

    always_comb
    begin
        result.status          = status;
        result.lifecycle       = nxt.life;
        result.generation_out  = nxt.generation;
        result.source_out      = nxt.source;
        result.failure_count   = nxt.fail_run;
        result.validated_at_ms = nxt.had_success ? nxt.success_time : nxt.learned_time;
        result.stale_after_ms  = nxt.expiry_time;
        result.failed_at_ms    = nxt.failure_time;
    end

endmodule

FILE: rtl/direct_path_freshness_tracker.sv
// top level of the direct path freshness tracker
//
//  channel | dir | transaction                                   | handshake
//  req     | in  | opcode, source, time, generation, success     | valid/ready
//  rsp     | out | status, lifecycle, path fields after the step | valid/ready
//  cfg     | in  | register index and data                       | cfg_we only
//
// two register stages: request register, then path state and response register.
// one transaction per cycle sustained while the response side takes each response.
// the state update and the response come from one short pass of compare/add logic.
// a stalled response holds the request register; the request side keeps taking
// a transaction as long as the request register empties in the same cycle.
// rst_n clears the path state, both valid flags and loads register defaults.
module direct_path_freshness_tracker (
    input  logic                              clk,
    input  logic                              rst_n,
    dpft_req_if.sink                          req,
    dpft_rsp_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [dpft_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dpft_pkg::CFG_DATA_W-1:0]   cfg_data
);

    dpft_pkg::cfg_t        cfg_reg;
    dpft_pkg::item_t       item_reg;
    logic                  item_vld_reg;
    dpft_pkg::path_state_t state_reg;
    dpft_pkg::path_state_t state_next;
    dpft_pkg::result_t     rsp_reg;
    dpft_pkg::result_t     rsp_next;
    logic                  rsp_vld_reg;
    logic                  advance;

    // request register moves into the response register when that one is free
    assign advance   = item_vld_reg && (!rsp_vld_reg || rsp.ready);
    assign req.ready = !item_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_age_ms        <= dpft_pkg::MAX_AGE_RESET;
            cfg_reg.failure_threshold <= dpft_pkg::FAIL_THRESH_RESET;
        end
        else if (cfg_we)
        begin
            case (dpft_pkg::cfg_idx_t'(cfg_index))
                dpft_pkg::CFG_MAX_AGE:
                    cfg_reg.max_age_ms <= cfg_data;
                dpft_pkg::CFG_FAIL_THRESH:
                    cfg_reg.failure_threshold <= cfg_data[dpft_pkg::FAIL_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            item_vld_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.opcode      <= dpft_pkg::op_t'(req.opcode);
            item_reg.path_source <= req.path_source;
            item_reg.now_ms      <= req.now_ms;
            item_reg.claimed_gen <= req.claimed_gen;
            item_reg.success     <= req.success;
        end
    end

    dpft_step u_step (
        .item   (item_reg),
        .cur    (state_reg),
        .cfg    (cfg_reg),
        .nxt    (state_next),
        .result (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= '0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                rsp_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid           = rsp_vld_reg;
    assign rsp.status          = rsp_reg.status;
    assign rsp.lifecycle       = rsp_reg.lifecycle;
    assign rsp.generation_out  = rsp_reg.generation_out;
    assign rsp.source_out      = rsp_reg.source_out;
    assign rsp.failure_count   = rsp_reg.failure_count;
    assign rsp.validated_at_ms = rsp_reg.validated_at_ms;
    assign rsp.stale_after_ms  = rsp_reg.stale_after_ms;
    assign rsp.failed_at_ms    = rsp_reg.failed_at_ms;

endmodule

FILE: tb/tb_top.sv
// self-checking testbench of the direct path freshness tracker
module tb_top;
    import dpft_pkg::*;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t want;
    } dir_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    dpft_req_if req_ch ();
    dpft_rsp_if rsp_ch ();

    direct_path_freshness_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predicted path state and register copy
    path_state_t track;
    cfg_t        regs;

    result_t     pending_rsp[$];
    dir_row_t    dir_rows[$];
    int          mismatches = 0;
    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;
    logic [TIME_W-1:0] wall_ms = '0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("mismatch on %s: got %h, expected %h", what, got, want);
    endtask

    // next path state and the response for one request transaction
    function automatic result_t advance_path(item_t it);
        result_t           r;
        status_t           st;
        logic [GEN_W-1:0]  g;
        logic [TIME_W-1:0] age;
        st  = ST_NONE;
        age = it.now_ms - (track.had_success ? track.success_time : track.learned_time);
        case (it.opcode)
            OP_CLEAR:
            begin
                track = '0;
                st    = ST_APPLIED;
            end
            OP_LEARN:
            begin
                if (it.path_source != 0 && it.path_source < SOURCE_COUNT &&
                    track.generation != GEN_MAX)
                begin
                    g                  = track.generation + 1'b1;
                    track              = '0;
                    track.learned_time = it.now_ms;
                    track.expiry_time  = it.now_ms + regs.max_age_ms;
                    track.generation   = g;
                    track.source       = it.path_source;
                    track.life         = LIFE_VALID;
                    st                 = ST_APPLIED;
                end
            end
            OP_EXPIRE:
            begin
                if (track.life == LIFE_VALID && age > regs.max_age_ms)
                begin
                    track.life = LIFE_EXPIRED;
                    if (track.generation != GEN_MAX)
                        track.generation = track.generation + 1'b1;
                    st = ST_APPLIED;
                end
            end
            default:
            begin
                if (it.claimed_gen == 0 || it.claimed_gen != track.generation ||
                    track.life != LIFE_VALID)
                    st = ST_STALE;
                else if (it.success)
                begin
                    track.success_time = it.now_ms;
                    track.had_success  = 1'b1;
                    track.expiry_time  = it.now_ms + regs.max_age_ms;
                    track.fail_run     = '0;
                    st                 = ST_APPLIED;
                end
                else
                begin
                    track.failure_time = it.now_ms;
                    if (track.fail_run != FAIL_MAX)
                        track.fail_run = track.fail_run + 1'b1;
                    if (track.fail_run < regs.failure_threshold)
                        st = ST_APPLIED;
                    else
                    begin
                        track.life = LIFE_FAILED;
                        if (track.generation != GEN_MAX)
                            track.generation = track.generation + 1'b1;
                        st = ST_FLOOD;
                    end
                end
            end
        endcase
        r.status          = st;
        r.lifecycle       = track.life;
        r.generation_out  = track.generation;
        r.source_out      = track.source;
        r.failure_count   = track.fail_run;
        r.validated_at_ms = track.had_success ? track.success_time : track.learned_time;
        r.stale_after_ms  = track.expiry_time;
        r.failed_at_ms    = track.failure_time;
        return r;
    endfunction

    // mostly well-formed requests against the current path, some noise
    function automatic item_t draw_request(int fail_pct);
        item_t             it;
        int                r;
        logic [TIME_W-1:0] base;
        wall_ms        = wall_ms + 32'($urandom_range(0, 2000));
        it.opcode      = OP_NOTE;
        it.path_source = 3'($urandom_range(1, SOURCE_COUNT - 1));
        it.now_ms      = ($urandom_range(0, 19) == 0) ? $urandom() : wall_ms;
        it.claimed_gen = track.generation;
        it.success     = ($urandom_range(0, 99) >= fail_pct);
        r = $urandom_range(0, 99);
        if (track.life != LIFE_VALID && $urandom_range(0, 1) == 0)
            it.opcode = OP_LEARN;
        else if (r < 4)
            it.opcode = OP_CLEAR;
        else if (r < 16)
        begin
            it.opcode = OP_LEARN;
            if ($urandom_range(0, 4) == 0)
                it.path_source = 3'($urandom_range(0, 7));
        end
        else if (r < 34)
        begin
            it.opcode = OP_EXPIRE;
            // land right around the age limit
            if ($urandom_range(0, 2) != 0)
            begin
                base = track.had_success ? track.success_time : track.learned_time;
                it.now_ms = base + regs.max_age_ms + 32'($urandom_range(0, 2)) - 32'd1;
            end
        end
        else
        begin
            case ($urandom_range(0, 9))
                0: it.claimed_gen = '0;
                1: it.claimed_gen = $urandom();
                2: it.claimed_gen = track.generation + 1'b1;
                default: ;
            endcase
        end
        if ($urandom_range(0, 9) == 0)
            it.path_source = 3'($urandom_range(0, 7));
        return it;
    endfunction

    task automatic send_item(item_t it, bit typed, result_t want);
        int      gap;
        result_t predicted;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.opcode      <= it.opcode;
        req_ch.path_source <= it.path_source;
        req_ch.now_ms      <= it.now_ms;
        req_ch.claimed_gen <= it.claimed_gen;
        req_ch.success     <= it.success;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        predicted = advance_path(it);
        pending_rsp.push_back(typed ? want : predicted);
    endtask

    task automatic end_burst();
        @(negedge clk);
        req_ch.valid <= 1'b0;
    endtask

    task automatic drain_responses();
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(logic [TIME_W-1:0] age, logic [FAIL_W-1:0] thresh);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_AGE;
        cfg_data  <= age;
        @(negedge clk);
        cfg_index <= CFG_FAIL_THRESH;
        cfg_data  <= CFG_DATA_W'(thresh);
        @(negedge clk);
        cfg_we <= 1'b0;
        regs.max_age_ms        = age;
        regs.failure_threshold = thresh;
    endtask

    task automatic run_phase(logic [TIME_W-1:0] age, logic [FAIL_W-1:0] thresh, int count,
                             int fail_pct, bit squeeze);
        item_t it;
        drain_responses();
        set_config(age, thresh);
        wall_ms = $urandom();
        if (squeeze)
            hold_req = 1'b1;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                idle_on = (squeeze && i < 80) ? 1'b0 : ($urandom_range(0, 3) != 0);
            it = draw_request(fail_pct);
            send_item(it, 1'b0, '0);
        end
        end_burst();
    endtask

    // learn, then an unbroken run of failures up to the widest threshold
    task automatic run_fail_streak();
        item_t it;
        drain_responses();
        set_config('1, FAIL_MAX);
        idle_on        = 1'b1;
        it.opcode      = OP_LEARN;
        it.path_source = 3'($urandom_range(1, SOURCE_COUNT - 1));
        it.now_ms      = $urandom();
        it.claimed_gen = $urandom();
        it.success     = 1'b0;
        send_item(it, 1'b0, '0);
        for (int i = 0; i < 257; i++)
        begin
            if (i % 40 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            it.opcode      = OP_NOTE;
            it.path_source = 3'($urandom_range(0, 7));
            it.now_ms      = $urandom();
            it.claimed_gen = track.generation;
            it.success     = 1'b0;
            send_item(it, 1'b0, '0);
        end
        end_burst();
    endtask

    task automatic add_row(item_t it, bit typed, result_t want);
        dir_row_t row;
        row.it    = it;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    // response side: random stalls plus one long hold-off on request
    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (60) @(negedge clk);
            end
            else
            begin
                stall = idle_on ? $urandom_range(0, 6) : 0;
                if (stall > 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_ch.valid !== 1'b1);
        end
    end

    always @(posedge clk)
    begin : rsp_check
        result_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_rsp.size() == 0)
                report_mismatch("transaction with nothing expected", 32'(rsp_ch.status), '0);
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
                if (rsp_ch.lifecycle !== want.lifecycle)
                    report_mismatch("lifecycle", 32'(rsp_ch.lifecycle), 32'(want.lifecycle));
                if (rsp_ch.generation_out !== want.generation_out)
                    report_mismatch("generation_out", rsp_ch.generation_out, want.generation_out);
                if (rsp_ch.source_out !== want.source_out)
                    report_mismatch("source_out", 32'(rsp_ch.source_out), 32'(want.source_out));
                if (rsp_ch.failure_count !== want.failure_count)
                    report_mismatch("failure_count", 32'(rsp_ch.failure_count),
                                    32'(want.failure_count));
                if (rsp_ch.validated_at_ms !== want.validated_at_ms)
                    report_mismatch("validated_at_ms", rsp_ch.validated_at_ms,
                                    want.validated_at_ms);
                if (rsp_ch.stale_after_ms !== want.stale_after_ms)
                    report_mismatch("stale_after_ms", rsp_ch.stale_after_ms,
                                    want.stale_after_ms);
                if (rsp_ch.failed_at_ms !== want.failed_at_ms)
                    report_mismatch("failed_at_ms", rsp_ch.failed_at_ms, want.failed_at_ms);
            end
        end
    end

    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = '0;
        cfg_data               = '0;
        req_ch.valid           = 1'b0;
        req_ch.opcode          = '0;
        req_ch.path_source     = '0;
        req_ch.now_ms          = '0;
        req_ch.claimed_gen     = '0;
        req_ch.success         = 1'b0;
        track                  = '0;
        regs.max_age_ms        = MAX_AGE_RESET;
        regs.failure_threshold = FAIL_THRESH_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows at reset register values
        add_row('{OP_CLEAR, 3'd0, 32'd0, 32'd0, 1'b0}, 1'b1,
                '{ST_APPLIED, LIFE_NONE, 32'd0, 3'd0, 8'd0, 32'd0, 32'd0, 32'd0});
        add_row('{OP_LEARN, 3'd0, 32'd5, 32'd0, 1'b1}, 1'b1,
                '{ST_NONE, LIFE_NONE, 32'd0, 3'd0, 8'd0, 32'd0, 32'd0, 32'd0});
        add_row('{OP_LEARN, 3'd6, 32'd5, 32'd0, 1'b1}, 1'b1,
                '{ST_NONE, LIFE_NONE, 32'd0, 3'd0, 8'd0, 32'd0, 32'd0, 32'd0});
        add_row('{OP_LEARN, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0}, 1'b1,
                '{ST_NONE, LIFE_NONE, 32'd0, 3'd0, 8'd0, 32'd0, 32'd0, 32'd0});
        add_row('{OP_NOTE, 3'd1, 32'd5, 32'd0, 1'b1}, 1'b1,
                '{ST_STALE, LIFE_NONE, 32'd0, 3'd0, 8'd0, 32'd0, 32'd0, 32'd0});
        add_row('{OP_EXPIRE, 3'd1, 32'hFFFF_FFFF, 32'd0, 1'b0}, 1'b1,
                '{ST_NONE, LIFE_NONE, 32'd0, 3'd0, 8'd0, 32'd0, 32'd0, 32'd0});
        add_row('{OP_LEARN, 3'd1, 32'd1000, 32'd0, 1'b0}, 1'b1,
                '{ST_APPLIED, LIFE_VALID, 32'd1, 3'd1, 8'd0, 32'd1000, 32'd601000, 32'd0});
        add_row('{OP_NOTE, 3'd0, 32'd2000, 32'd1, 1'b1}, 1'b1,
                '{ST_APPLIED, LIFE_VALID, 32'd1, 3'd1, 8'd0, 32'd2000, 32'd602000, 32'd0});
        // wrong generation is stale
        add_row('{OP_NOTE, 3'd0, 32'd2500, 32'd2, 1'b1}, 1'b1,
                '{ST_STALE, LIFE_VALID, 32'd1, 3'd1, 8'd0, 32'd2000, 32'd602000, 32'd0});
        add_row('{OP_NOTE, 3'd0, 32'd3000, 32'd1, 1'b0}, 1'b1,
                '{ST_APPLIED, LIFE_VALID, 32'd1, 3'd1, 8'd1, 32'd2000, 32'd602000, 32'd3000});
        add_row('{OP_NOTE, 3'd0, 32'd3001, 32'd1, 1'b0}, 1'b1,
                '{ST_APPLIED, LIFE_VALID, 32'd1, 3'd1, 8'd2, 32'd2000, 32'd602000, 32'd3001});
        add_row('{OP_NOTE, 3'd0, 32'd3002, 32'd1, 1'b0}, 1'b1,
                '{ST_FLOOD, LIFE_FAILED, 32'd2, 3'd1, 8'd3, 32'd2000, 32'd602000, 32'd3002});
        // failed path no longer takes results
        add_row('{OP_NOTE, 3'd0, 32'd3003, 32'd2, 1'b1}, 1'b1,
                '{ST_STALE, LIFE_FAILED, 32'd2, 3'd1, 8'd3, 32'd2000, 32'd602000, 32'd3002});
        // learn at the top of the clock, expiry wraps
        add_row('{OP_LEARN, 3'd5, 32'hFFFF_FFFF, 32'd0, 1'b0}, 1'b1,
                '{ST_APPLIED, LIFE_VALID, 32'd3, 3'd5, 8'd0, 32'hFFFF_FFFF, 32'd599999, 32'd0});
        add_row('{OP_EXPIRE, 3'd0, 32'd600000, 32'd0, 1'b0}, 1'b1,
                '{ST_APPLIED, LIFE_EXPIRED, 32'd4, 3'd5, 8'd0, 32'hFFFF_FFFF, 32'd599999,
                  32'd0});
        add_row('{OP_LEARN, 3'd2, 32'd10, 32'd0, 1'b1}, 1'b0, '0);
        add_row('{OP_EXPIRE, 3'd2, 32'd600010, 32'd0, 1'b0}, 1'b0, '0);
        add_row('{OP_EXPIRE, 3'd2, 32'd600011, 32'd0, 1'b0}, 1'b0, '0);
        add_row('{OP_LEARN, 3'd3, 32'd0, 32'hFFFF_FFFF, 1'b0}, 1'b0, '0);
        add_row('{OP_NOTE, 3'd4, 32'd500000, 32'd7, 1'b1}, 1'b0, '0);
        add_row('{OP_EXPIRE, 3'd0, 32'd1100000, 32'd7, 1'b1}, 1'b0, '0);
        add_row('{OP_EXPIRE, 3'd0, 32'd1100001, 32'd7, 1'b1}, 1'b0, '0);
        add_row('{OP_LEARN, 3'd4, 32'd7, 32'd0, 1'b1}, 1'b0, '0);
        add_row('{OP_NOTE, 3'd7, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0}, 1'b0, '0);
        add_row('{OP_CLEAR, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 1'b1,
                '{ST_APPLIED, LIFE_NONE, 32'd0, 3'd0, 8'd0, 32'd0, 32'd0, 32'd0});
        foreach (dir_rows[i])
            send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
        end_burst();

        run_phase('0, 8'd1, 160, 30, 1'b0);
        run_fail_streak();
        run_phase('1, FAIL_MAX, 160, 50, 1'b0);
        run_phase(MAX_AGE_RESET, FAIL_THRESH_RESET, 160, 30, 1'b1);
        run_phase(32'($urandom_range(1, 5000)), 8'($urandom_range(1, 8)), 160, 40, 1'b0);
        run_phase(32'($urandom_range(1, 5000)), 8'($urandom_range(1, 8)), 160, 40, 1'b0);
        run_phase($urandom(), 8'($urandom_range(1, 255)), 160, 40, 1'b0);
        run_phase(32'd1, 8'd2, 160, 40, 1'b0);

        drain_responses();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
